[rtl/vlqp_pkg.sv]
`default_nettype none
package vlqp_pkg;

    // Default for the length-field byte limit
    localparam int unsigned MAX_LENGTH_BYTES_DFLT = 10;

    // Data bits and continuation flag of one base-128 byte
    localparam logic [7:0] VLQ_DATA_MASK = 8'h7F;
    localparam int unsigned VLQ_DATA_BITS = 7;

    // Parser phase
    typedef enum logic [1:0] {
        PH_KEY_LEN  = 2'd0,
        PH_VAL_LEN  = 2'd1,
        PH_KEY_DATA = 2'd2,
        PH_VAL_DATA = 2'd3
    } t_phase;

    // Input kind codes
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Result role codes
    localparam logic [2:0] ROLE_KEY_LEN  = 3'd0;
    localparam logic [2:0] ROLE_VAL_LEN  = 3'd1;
    localparam logic [2:0] ROLE_KEY_DATA = 3'd2;
    localparam logic [2:0] ROLE_VAL_DATA = 3'd3;
    localparam logic [2:0] ROLE_FINISH   = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_LEN_LONG   = 2'd1;
    localparam logic [1:0] STAT_UNFINISHED = 2'd2;

    // Input beat
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [2:0]  role;
        logic [7:0]  byte_out;
        logic        length_done;
        logic [63:0] length_value;
        logic        key_end;
        logic        record_done;
        logic [1:0]  status;
        logic [63:0] records_seen;
    } t_out_item;

endpackage
`default_nettype wire

[rtl/vlq_length_prefixed_record_parser_unit.sv]
`default_nettype none
// Length-prefixed record parser. Takes one stream byte (or a finish check)
// per beat and returns one tagged result beat per input beat, in order.
// A new beat is accepted every cycle while the output side keeps up; the
// parser state is updated once per byte, so sustained throughput is one
// beat per clock, and each beat passes through the input register, then
// the result register. Backpressure on the output stalls the input
// register, which in turn drops o_in_ready only when both are full.
module vlq_length_prefixed_record_parser_unit #(
    parameter int unsigned MAX_LENGTH_BYTES = vlqp_pkg::MAX_LENGTH_BYTES_DFLT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  vlqp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output vlqp_pkg::t_out_item o_out_item
);
    import vlqp_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      w_s2_free;
    logic      w_fire;
    t_out_item w_result;

    // Pipeline flow control
    assign w_s2_free  = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_s2_free;
    assign o_in_ready = !r_in_valid || w_s2_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    vlqp_core #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .o_result(w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

[rtl/vlqp_core.sv]
`default_nettype none
module vlqp_core #(
    parameter int unsigned MAX_LENGTH_BYTES = vlqp_pkg::MAX_LENGTH_BYTES_DFLT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  vlqp_pkg::t_in_item  i_item,
    output vlqp_pkg::t_out_item o_result
);
    import vlqp_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    t_phase             r_phase, n_phase;
    logic [63:0]        r_accum, n_accum;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [63:0]        r_key_len, n_key_len;
    logic [63:0]        r_val_len, n_val_len;
    logic [63:0]        r_rcvd, n_rcvd;
    logic [63:0]        r_record_count, n_record_count;

    logic [63:0]        w_accum_merged;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic [63:0]        w_rcvd_inc;
    t_out_item          w_res;

    // Merge this byte's 7 data bits at the slot picked by the byte count
    always_comb begin
        w_accum_merged = r_accum;
        for (int k = 0; k < MAX_LENGTH_BYTES; k++) begin
            if (r_cnt == CNT_W'(k)) begin
                w_accum_merged = r_accum |
                    (64'(i_item.data_byte & VLQ_DATA_MASK) << (VLQ_DATA_BITS * k));
            end
        end
    end

    assign w_cnt_inc  = r_cnt + 1'b1;
    assign w_rcvd_inc = r_rcvd + 64'd1;

    // Next state and result for the beat in the input register
    always_comb begin
        n_phase        = r_phase;
        n_accum        = r_accum;
        n_cnt          = r_cnt;
        n_key_len      = r_key_len;
        n_val_len      = r_val_len;
        n_rcvd         = r_rcvd;
        n_record_count = r_record_count;
        w_res          = '0;

        if (i_item.kind == KIND_FINISH) begin
            w_res.role = ROLE_FINISH;
            if (r_phase != PH_KEY_LEN || r_cnt != '0) begin
                w_res.status = STAT_UNFINISHED;
            end
        end else begin
            w_res.role     = {1'b0, r_phase};
            w_res.byte_out = i_item.data_byte;
            case (r_phase)
                PH_KEY_LEN, PH_VAL_LEN: begin
                    n_accum = w_accum_merged;
                    n_cnt   = w_cnt_inc;
                    if (!i_item.data_byte[7]) begin
                        // last byte of the length field
                        w_res.length_done  = 1'b1;
                        w_res.length_value = w_accum_merged;
                        n_accum = '0;
                        n_cnt   = '0;
                        if (r_phase == PH_KEY_LEN) begin
                            n_key_len = w_accum_merged;
                            n_phase   = PH_VAL_LEN;
                        end else begin
                            n_val_len = w_accum_merged;
                            n_rcvd    = '0;
                            if (r_key_len != '0) begin
                                n_phase = PH_KEY_DATA;
                            end else if (w_accum_merged != '0) begin
                                n_phase = PH_VAL_DATA;
                            end else begin
                                w_res.record_done = 1'b1;
                            end
                        end
                    end else if (w_cnt_inc >= CNT_W'(MAX_LENGTH_BYTES)) begin
                        // overlong field: drop it and start the same field over
                        w_res.status = STAT_LEN_LONG;
                        n_accum = '0;
                        n_cnt   = '0;
                    end
                end
                PH_KEY_DATA: begin
                    n_rcvd = w_rcvd_inc;
                    if (w_rcvd_inc >= r_key_len) begin
                        w_res.key_end = 1'b1;
                        n_rcvd = '0;
                        if (r_val_len != '0) begin
                            n_phase = PH_VAL_DATA;
                        end else begin
                            w_res.record_done = 1'b1;
                        end
                    end
                end
                default: begin
                    n_rcvd = w_rcvd_inc;
                    if (w_rcvd_inc >= r_val_len) begin
                        w_res.record_done = 1'b1;
                    end
                end
            endcase

            // record end clears the record state
            if (w_res.record_done) begin
                n_record_count = r_record_count + 64'd1;
                n_key_len      = '0;
                n_val_len      = '0;
                n_rcvd         = '0;
                n_phase        = PH_KEY_LEN;
            end
        end
        w_res.records_seen = n_record_count;
    end

    assign o_result = w_res;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_KEY_LEN;
            r_accum        <= '0;
            r_cnt          <= '0;
            r_key_len      <= '0;
            r_val_len      <= '0;
            r_rcvd         <= '0;
            r_record_count <= '0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_accum        <= n_accum;
            r_cnt          <= n_cnt;
            r_key_len      <= n_key_len;
            r_val_len      <= n_val_len;
            r_rcvd         <= n_rcvd;
            r_record_count <= n_record_count;
        end
    end

    // Byte count never reaches the limit between beats
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(MAX_LENGTH_BYTES))
        else $error("length byte count out of range");

    // Key length phase starts with a clean record
    a_clean_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_KEY_LEN |-> (r_key_len == '0 && r_val_len == '0 && r_rcvd == '0))
        else $error("record state not cleared");

    // Key data phase never overruns the key
    a_key_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_KEY_DATA |-> r_rcvd < r_key_len)
        else $error("key byte count overrun");

    // A completed record bumps the count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_res.record_done) |=> r_record_count == $past(r_record_count) + 64'd1)
        else $error("record count did not advance");

endmodule
`default_nettype wire
